@@ sv/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held.
`define SAWT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sawt assertion failed");

// Next-cycle implication, sampled on i_clk, off while reset is held.
`define SAWT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sawt assertion failed");

`endif

@@ sv/sawt_pkg.sv @@
// Shared constants and types of the selective ack window tracker.
package sawt_pkg;

    localparam int WIN_BITS = 64;
    localparam int ID_W     = 16;
    localparam int CNT_W    = 15;
    localparam int ST_W     = 2;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [ST_W-1:0] ST_DUP     = 2'd0;
    localparam logic [ST_W-1:0] ST_NEWER   = 2'd1;
    localparam logic [ST_W-1:0] ST_OLD     = 2'd2;
    localparam logic [ST_W-1:0] ST_TOO_OLD = 2'd3;

    // Word index of the loss tracking enable register.
    localparam logic REG_TRACK_LOSS = 1'b0;

    localparam logic [ID_W-1:0]     RESET_NEWEST = 16'hFFFF;
    localparam logic [WIN_BITS-1:0] RESET_WINDOW = {WIN_BITS{1'b1}};

    typedef struct packed {
        logic [ID_W-1:0]     newest;
        logic [WIN_BITS-1:0] window;
        logic [WIN_BITS-1:0] fresh;
        logic                is_fresh;
    } t_state;

    typedef struct packed {
        logic [WIN_BITS-1:0] lost;
        logic [ID_W-1:0]     gap_first;
        logic [CNT_W-1:0]    gap_count;
    } t_loss;

endpackage

@@ sv/sawt_update.sv @@
// Next window state and loss report for one ack transaction.
module sawt_update (
    input  sawt_pkg::t_state                   i_state,
    input  logic                               i_track_loss,
    input  logic [sawt_pkg::ID_W-1:0]          i_new_ack,
    input  logic [sawt_pkg::WIN_BITS-1:0]      i_ack_mask,
    output logic [sawt_pkg::ST_W-1:0]          o_status,
    output sawt_pkg::t_state                   o_state,
    output sawt_pkg::t_loss                    o_loss
);

    logic [sawt_pkg::ID_W-1:0]     delta;
    logic [sawt_pkg::ID_W-1:0]     delta_m1;
    logic [sawt_pkg::ID_W-1:0]     back;
    logic [sawt_pkg::ID_W-1:0]     back_m1;
    logic                          is_newer;
    logic [6:0]                    shift;
    logic [sawt_pkg::WIN_BITS-1:0] win_shl;
    logic [sawt_pkg::WIN_BITS-1:0] top;
    logic [sawt_pkg::WIN_BITS-1:0] base;
    logic [sawt_pkg::WIN_BITS-1:0] src;
    logic                          merge;

    assign delta    = i_new_ack - i_state.newest;
    assign delta_m1 = delta - 16'd1;
    assign back     = 16'd0 - delta;
    assign back_m1  = back - 16'd1;
    assign is_newer = (delta != 16'd0) && !delta[15];

    // Saturate the slide at a full window; a full slide empties it.
    assign shift   = (delta < 16'd64) ? delta[6:0] : 7'd64;
    assign win_shl = shift[6] ? '0 : (i_state.window << shift[5:0]);
    assign top     = shift[6] ? {sawt_pkg::WIN_BITS{1'b1}}
                              : ~({sawt_pkg::WIN_BITS{1'b1}} >> shift[5:0]);

    always_comb begin
        if (delta == 16'd0) begin
            o_status = sawt_pkg::ST_DUP;
        end else if (is_newer) begin
            o_status = sawt_pkg::ST_NEWER;
        end else if (back <= 16'd64) begin
            o_status = sawt_pkg::ST_OLD;
        end else begin
            o_status = sawt_pkg::ST_TOO_OLD;
        end
    end

    always_comb begin
        base             = i_state.window;
        src              = i_ack_mask;
        merge            = 1'b1;
        o_state          = i_state;
        o_state.is_fresh = 1'b0;
        o_loss           = '0;
        case (o_status)
            sawt_pkg::ST_DUP: begin
                merge = 1'b1;
            end
            sawt_pkg::ST_NEWER: begin
                o_state.newest   = i_new_ack;
                o_state.is_fresh = 1'b1;
                if (i_track_loss) begin
                    o_loss.lost = ~i_state.window & top;
                end
                if (delta > 16'd64) begin
                    base = '0;
                    if (i_track_loss && delta > 16'd65) begin
                        o_loss.gap_count = delta[sawt_pkg::CNT_W-1:0] - 15'd65;
                        o_loss.gap_first = i_state.newest + 16'd1;
                    end
                end else begin
                    // Old newest id lands at bit delta-1.
                    base = win_shl | ({{(sawt_pkg::WIN_BITS-1){1'b0}}, 1'b1} << delta_m1[5:0]);
                end
            end
            sawt_pkg::ST_OLD: begin
                src = (back[6] ? '0 : (i_ack_mask << back[5:0]))
                    | ({{(sawt_pkg::WIN_BITS-1){1'b0}}, 1'b1} << back_m1[5:0]);
            end
            default: begin
                merge = 1'b0;
            end
        endcase
        if (merge) begin
            o_state.fresh  = src & ~base;
            o_state.window = base | src;
        end
    end

endmodule

@@ sv/sawt_apb_regs.sv @@
// APB register block holding the loss tracking enable.
module sawt_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sawt_pkg::ADDR_W-1:0]       paddr,
    input  logic [sawt_pkg::DATA_W-1:0]       pwdata,
    output logic [sawt_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    output logic                              o_track_loss
);

    logic r_track_loss;
    logic n_track_loss;
    logic wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && pready
                 && (paddr[2] == sawt_pkg::REG_TRACK_LOSS);

    assign n_track_loss = wr_hit ? pwdata[0] : r_track_loss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_loss <= 1'b0;
        end else begin
            r_track_loss <= n_track_loss;
        end
    end

    assign prdata = (paddr[2] == sawt_pkg::REG_TRACK_LOSS)
                  ? {{(sawt_pkg::DATA_W-1){1'b0}}, r_track_loss} : '0;
    assign o_track_loss = r_track_loss;

endmodule

@@ sv/selective_ack_window_tracker.sv @@
// Top level of the selective ack window tracker.
//   channel | direction | handshake                | payload
//   in      | sink      | i_in_valid / o_in_stall  | i_new_ack, i_ack_mask
//   out     | source    | o_out_valid / i_out_stall| status, window, fresh, loss
//   cfg     | APB slave | psel, penable, pready    | track_loss at byte 0
// One transaction per cycle while the output does not stall; the result passes through
// the input register, then the window update into the result register.
// The window state updates as a transaction leaves the input register, so the
// next transaction in the input register sees it with no bubble.
// Synchronous active-low reset restores newest id 0xFFFF and a full window.
// An output stall holds the result; the input register still takes one more.
module selective_ack_window_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [sawt_pkg::ID_W-1:0]           i_new_ack,
    input  logic [sawt_pkg::WIN_BITS-1:0]       i_ack_mask,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sawt_pkg::ST_W-1:0]           o_ack_status,
    output logic [sawt_pkg::ID_W-1:0]           o_last_ack,
    output logic [sawt_pkg::WIN_BITS-1:0]       o_acked_mask,
    output logic [sawt_pkg::WIN_BITS-1:0]       o_fresh_mask,
    output logic                                o_last_is_fresh,
    output logic [sawt_pkg::WIN_BITS-1:0]       o_lost_mask,
    output logic [sawt_pkg::ID_W-1:0]           o_gap_first_id,
    output logic [sawt_pkg::CNT_W-1:0]          o_gap_lost_count,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sawt_pkg::ADDR_W-1:0]         paddr,
    input  logic [sawt_pkg::DATA_W-1:0]         pwdata,
    output logic [sawt_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    logic                            track_loss;
    logic                            r_in_vld;
    logic [sawt_pkg::ID_W-1:0]       r_in_ack;
    logic [sawt_pkg::WIN_BITS-1:0]   r_in_mask;
    sawt_pkg::t_state                r_state;
    sawt_pkg::t_state                n_state;
    logic [sawt_pkg::ST_W-1:0]       n_status;
    sawt_pkg::t_loss                 n_loss;
    logic                            r_out_vld;
    logic [sawt_pkg::ST_W-1:0]       r_out_status;
    sawt_pkg::t_state                r_out_state;
    sawt_pkg::t_loss                 r_out_loss;
    logic                            out_ready;
    logic                            in_take;
    logic                            fire;

    sawt_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_track_loss (track_loss)
    );

    sawt_update u_update (
        .i_state      (r_state),
        .i_track_loss (track_loss),
        .i_new_ack    (r_in_ack),
        .i_ack_mask   (r_in_mask),
        .o_status     (n_status),
        .o_state      (n_state),
        .o_loss       (n_loss)
    );

    assign out_ready  = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && out_ready;
    assign o_in_stall = r_in_vld && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '{newest:   sawt_pkg::RESET_NEWEST,
                           window:   sawt_pkg::RESET_WINDOW,
                           fresh:    '0,
                           is_fresh: 1'b0};
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_ack  <= i_new_ack;
            r_in_mask <= i_ack_mask;
        end
        if (fire) begin
            r_out_status <= n_status;
            r_out_state  <= n_state;
            r_out_loss   <= n_loss;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_ack_status     = r_out_status;
    assign o_last_ack       = r_out_state.newest;
    assign o_acked_mask     = r_out_state.window;
    assign o_fresh_mask     = r_out_state.fresh;
    assign o_last_is_fresh  = r_out_state.is_fresh;
    assign o_lost_mask      = r_out_loss.lost;
    assign o_gap_first_id   = r_out_loss.gap_first;
    assign o_gap_lost_count = r_out_loss.gap_count;

endmodule

@@ sv/sawt_checker.sv @@
// Port-level checker for the selective ack window tracker, with its bind.
`include "assert_macros.svh"

module sawt_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [sawt_pkg::ST_W-1:0]           o_ack_status,
    input logic [sawt_pkg::WIN_BITS-1:0]       o_acked_mask,
    input logic [sawt_pkg::WIN_BITS-1:0]       o_fresh_mask,
    input logic                                o_last_is_fresh,
    input logic [sawt_pkg::WIN_BITS-1:0]       o_lost_mask,
    input logic [sawt_pkg::ID_W-1:0]           o_gap_first_id,
    input logic [sawt_pkg::CNT_W-1:0]          o_gap_lost_count
);

    `SAWT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `SAWT_ASSERT_NOW(a_fresh_flag, o_out_valid, o_last_is_fresh == (o_ack_status == sawt_pkg::ST_NEWER))
    `SAWT_ASSERT_NOW(a_fresh_in_window, o_out_valid, (o_fresh_mask & ~o_acked_mask) == '0)
    `SAWT_ASSERT_NOW(a_loss_on_slide, o_out_valid && (o_ack_status != sawt_pkg::ST_NEWER), (o_lost_mask == '0) && (o_gap_lost_count == '0))
    `SAWT_ASSERT_NOW(a_gap_id_zero, o_out_valid && (o_gap_lost_count == '0), o_gap_first_id == '0)

endmodule

bind selective_ack_window_tracker sawt_checker u_sawt_checker (.*);

@@ dv/tb_selective_ack_window_tracker.sv @@
// Self-checking testbench for the selective ack window tracker.
module tb_selective_ack_window_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HOLD_CYCLES = 200;
    localparam logic [sawt_pkg::ADDR_W-1:0] TRACK_LOSS_ADDR = {sawt_pkg::REG_TRACK_LOSS, 2'b00};

    typedef struct packed {
        logic [sawt_pkg::ST_W-1:0]     status;
        logic [sawt_pkg::ID_W-1:0]     last_ack;
        logic [sawt_pkg::WIN_BITS-1:0] acked;
        logic [sawt_pkg::WIN_BITS-1:0] fresh;
        logic                          last_fresh;
        logic [sawt_pkg::WIN_BITS-1:0] lost;
        logic [sawt_pkg::ID_W-1:0]     gap_first;
        logic [sawt_pkg::CNT_W-1:0]    gap_count;
    } t_ack_update;

    class t_scoreboard;
        logic [sawt_pkg::ID_W-1:0]     newest_id = sawt_pkg::RESET_NEWEST;
        logic [sawt_pkg::WIN_BITS-1:0] win = sawt_pkg::RESET_WINDOW;
        logic [sawt_pkg::WIN_BITS-1:0] fresh = '0;
        logic                          track_loss = 1'b0;
        t_ack_update                   expected_updates[$];
        int                            mismatches = 0;

        function void merge_into(logic [sawt_pkg::WIN_BITS-1:0] m);
            fresh = m & ~win;
            win   = win | m;
        endfunction

        function void predict_ack(logic [sawt_pkg::ID_W-1:0] ack,
                                  logic [sawt_pkg::WIN_BITS-1:0] mask);
            t_ack_update                   upd;
            logic [sawt_pkg::ID_W-1:0]     delta;
            int unsigned                   d;
            int unsigned                   shift;
            int unsigned                   back;
            logic [sawt_pkg::WIN_BITS-1:0] top;
            upd = '0;
            delta = ack - newest_id;
            d = {16'd0, delta};
            upd.last_fresh = 1'b0;
            if (d == 0) begin
                upd.status = sawt_pkg::ST_DUP;
                merge_into(mask);
            end else if (d < 32768) begin
                shift = (d < sawt_pkg::WIN_BITS) ? d : sawt_pkg::WIN_BITS;
                upd.status = sawt_pkg::ST_NEWER;
                if (track_loss) begin
                    // a shift by the full width clears, so top becomes all ones
                    top = ~({sawt_pkg::WIN_BITS{1'b1}} >> shift);
                    upd.lost = ~win & top;
                end
                win = win << shift;
                if (d > sawt_pkg::WIN_BITS) begin
                    win = '0;
                    if (track_loss && d > sawt_pkg::WIN_BITS + 1) begin
                        upd.gap_count = sawt_pkg::CNT_W'(d - sawt_pkg::WIN_BITS - 1);
                        upd.gap_first = newest_id + 16'd1;
                    end
                end else begin
                    win = win | (64'd1 << (d - 1));
                end
                newest_id = ack;
                upd.last_fresh = 1'b1;
                merge_into(mask);
            end else begin
                back = 65536 - d;
                if (back <= sawt_pkg::WIN_BITS) begin
                    upd.status = sawt_pkg::ST_OLD;
                    merge_into((mask << back) | (64'd1 << (back - 1)));
                end else begin
                    upd.status = sawt_pkg::ST_TOO_OLD;
                end
            end
            upd.last_ack = newest_id;
            upd.acked    = win;
            upd.fresh    = fresh;
            expected_updates.insert(expected_updates.size(), upd);
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", what, want, got);
        endfunction

        function void check_update(t_ack_update got);
            t_ack_update want;
            if (expected_updates.size() == 0) begin
                flag("unexpected update, last_ack", '0, 64'(got.last_ack));
                return;
            end
            want = expected_updates.pop_front();
            if (got.status !== want.status)
                flag("ack_status", 64'(want.status), 64'(got.status));
            if (got.last_ack !== want.last_ack)
                flag("last_ack", 64'(want.last_ack), 64'(got.last_ack));
            if (got.acked !== want.acked) flag("acked_mask", want.acked, got.acked);
            if (got.fresh !== want.fresh) flag("fresh_mask", want.fresh, got.fresh);
            if (got.last_fresh !== want.last_fresh)
                flag("last_is_fresh", 64'(want.last_fresh), 64'(got.last_fresh));
            if (got.lost !== want.lost) flag("lost_mask", want.lost, got.lost);
            if (got.gap_first !== want.gap_first)
                flag("gap_first_id", 64'(want.gap_first), 64'(got.gap_first));
            if (got.gap_count !== want.gap_count)
                flag("gap_lost_count", 64'(want.gap_count), 64'(got.gap_count));
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [sawt_pkg::ID_W-1:0]     i_new_ack = '0;
    logic [sawt_pkg::WIN_BITS-1:0] i_ack_mask = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [sawt_pkg::ST_W-1:0]     o_ack_status;
    logic [sawt_pkg::ID_W-1:0]     o_last_ack;
    logic [sawt_pkg::WIN_BITS-1:0] o_acked_mask;
    logic [sawt_pkg::WIN_BITS-1:0] o_fresh_mask;
    logic                          o_last_is_fresh;
    logic [sawt_pkg::WIN_BITS-1:0] o_lost_mask;
    logic [sawt_pkg::ID_W-1:0]     o_gap_first_id;
    logic [sawt_pkg::CNT_W-1:0]    o_gap_lost_count;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [sawt_pkg::ADDR_W-1:0]   paddr = '0;
    logic [sawt_pkg::DATA_W-1:0]   pwdata = '0;
    logic [sawt_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    t_scoreboard               sb;
    logic [sawt_pkg::ID_W-1:0] gen_newest = sawt_pkg::RESET_NEWEST;
    bit                        gaps_on = 1'b0;
    bit                        stall_on = 1'b0;
    bit                        hold_req = 1'b0;
    bit                        hold_done = 1'b0;

    selective_ack_window_tracker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_new_ack        (i_new_ack),
        .i_ack_mask       (i_ack_mask),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_ack_status     (o_ack_status),
        .o_last_ack       (o_last_ack),
        .o_acked_mask     (o_acked_mask),
        .o_fresh_mask     (o_fresh_mask),
        .o_last_is_fresh  (o_last_is_fresh),
        .o_lost_mask      (o_lost_mask),
        .o_gap_first_id   (o_gap_first_id),
        .o_gap_lost_count (o_gap_lost_count),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #2 i_clk = ~i_clk;

    // Check results before noting inputs; a result never belongs to this edge's input.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_update({o_ack_status, o_last_ack, o_acked_mask, o_fresh_mask,
                                 o_last_is_fresh, o_lost_mask, o_gap_first_id,
                                 o_gap_lost_count});
            if (i_in_valid && !o_in_stall)
                sb.predict_ack(i_new_ack, i_ack_mask);
        end
    end

    // Result side: random stall bursts, plus one long hold on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_done = 1'b1;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [sawt_pkg::WIN_BITS-1:0] pick_mask();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            3: return {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly a well-formed stream creeping forward, with reordering and jumps mixed in.
    function automatic logic [sawt_pkg::ID_W-1:0] pick_ack();
        int unsigned r;
        int unsigned d;
        r = $urandom_range(0, 99);
        if (r < 50)      d = $urandom_range(1, 8);
        else if (r < 58) d = 0;
        else if (r < 70) d = 65536 - $urandom_range(1, 64);
        else if (r < 78) d = $urandom_range(9, 64);
        else if (r < 83) d = $urandom_range(65, 70);
        else if (r < 87) d = $urandom_range(71, 32767);
        else if (r < 89) d = 32768;
        else if (r < 92) d = 65536 - $urandom_range(65, 32767);
        else if (r < 96) begin
            case ($urandom_range(0, 5))
                0: d = 64;
                1: d = 65;
                2: d = 66;
                3: d = 32767;
                4: d = 65535;
                default: d = 65536 - 64;
            endcase
        end else begin
            return sawt_pkg::ID_W'($urandom);
        end
        return gen_newest + sawt_pkg::ID_W'(d);
    endfunction

    task automatic send_ack(input logic [sawt_pkg::ID_W-1:0] ack,
                            input logic [sawt_pkg::WIN_BITS-1:0] mask);
        logic [sawt_pkg::ID_W-1:0] delta;
        i_in_valid <= 1'b1;
        i_new_ack  <= ack;
        i_ack_mask <= mask;
        do @(posedge i_clk); while (o_in_stall);
        delta = ack - gen_newest;
        if (delta != 16'd0 && delta < 16'd32768)
            gen_newest = ack;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Hold input until every expected update is back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_updates.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_set_track_loss(input logic val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TRACK_LOSS_ADDR;
        pwdata  <= sawt_pkg::DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // read back the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[0] !== val)
            sb.flag("track_loss readback", 64'(val), 64'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.track_loss = val;
    endtask

    task automatic run_directed();
        int unsigned                   steps[20] = '{0, 0, 1, 0, 64, 65, 66, 32767, 32768,
                                                     65535, 65472, 65471, 2, 63, 32769, 100,
                                                     1, 3, 0, 65535};
        logic [sawt_pkg::WIN_BITS-1:0] masks[20] = '{64'h0, '1, 64'h0, 64'h5555_5555_5555_5555,
                                                     64'h0, 64'hAAAA_AAAA_AAAA_AAAA, '1,
                                                     64'h0, '1, 64'h0, '1, '1, 64'h1,
                                                     64'h8000_0000_0000_0000,
                                                     64'hFFFF_0000_FFFF_0000,
                                                     64'h0123_4567_89AB_CDEF,
                                                     64'h0, 64'h3, 64'h0, '1};
        foreach (steps[i])
            send_ack(gen_newest + sawt_pkg::ID_W'(steps[i]), masks[i]);
    endtask

    task automatic run_phase(input int n, input logic loss, input bit gaps, input bit stalls,
                             input bit hold);
        wait_idle();
        apb_set_track_loss(loss);
        stall_on = stalls;
        if (hold)
            hold_req = 1'b1;
        for (int i = 0; i < n; i++) begin
            // keep offering back to back while the result side is held
            gaps_on = gaps && !(hold && i < 40);
            send_ack(pick_ack(), pick_mask());
        end
    endtask

    initial begin
        sb = new;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        apb_set_track_loss(1'b1);
        run_directed();
        run_phase(420, 1'b0, 1'b1, 1'b1, 1'b0);
        run_phase(420, 1'b1, 1'b1, 1'b1, 1'b1);
        run_phase(380, 1'b0, 1'b1, 1'b1, 1'b0);
        run_phase(400, 1'b1, 1'b0, 1'b0, 1'b0);
        wait_idle();
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_updates.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
